// ===== sv/dfbot_pkg.sv =====
// Shared types and constants of the frame buffer owner tracker.
package dfbot_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned FBYTES_W = 21;
  localparam int unsigned CNT32_W  = 32;
  // Buffer end address keeps one carry bit
  localparam int unsigned END_W    = ADDR_W + 1;
  // Remainder unit folds the upper half, then the lower half of each address
  localparam int unsigned MOD_STEPS = 2;
  localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

  localparam logic [FBYTES_W-1:0] FRAME_BYTES_RESET = FBYTES_W'(320 * 240 * 2);

  // Configuration register indexes
  localparam logic REG_POOL_BASE_ADDR = 1'b0;
  localparam logic REG_FRAME_BYTES    = 1'b1;

  typedef enum logic [2:0] {
    OP_PREP_RX    = 3'd0,
    OP_RX_DONE    = 3'd1,
    OP_QUEUE      = 3'd2,
    OP_LCD_SUBMIT = 3'd3,
    OP_FLUSH_DONE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    OWN_FREE    = 3'd0,
    OWN_DMA_RX  = 3'd1,
    OWN_CPU     = 3'd2,
    OWN_QUEUED  = 3'd3,
    OWN_DISPLAY = 3'd4
  } owner_t;

  typedef enum logic [1:0] {
    CACHE_NONE       = 2'd0,
    CACHE_INVALIDATE = 2'd1,
    CACHE_CLEAN      = 2'd2
  } cache_act_t;

  typedef enum logic [1:0] {
    DMA_NONE   = 2'd0,
    DMA_CAM_RX = 2'd1,
    DMA_LCD_TX = 2'd2
  } dma_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MOD,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic addr_load;
    logic mod_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_last;
    logic out_free;
  } dp_stat_t;

  // One result word
  typedef struct packed {
    logic               ok;
    owner_t             owner_after;
    logic [CNT32_W-1:0] frame_seq;
    logic [CNT32_W-1:0] frame_generation;
    cache_act_t         cache_action;
    logic [ADDR_W-1:0]  cache_addr;
    logic [ADDR_W-1:0]  cache_len;
    dma_act_t           dma_action;
    logic [ADDR_W-1:0]  dma_addr;
    logic               queue_push;
    logic [CNT32_W-1:0] stale_total;
    logic [CNT32_W-1:0] reuse_total;
  } result_t;

endpackage

// ===== sv/dfbot_ctrl.sv =====
// Sequencing state machine of the frame buffer owner tracker.
module dfbot_ctrl
  import dfbot_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (stat.mod_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ADDR: begin
        cmd.addr_load = 1'b1;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/dfbot_dp.sv =====
// Datapath: owner tables, buffer address, line alignment and result register.
module dfbot_dp
  import dfbot_pkg::*;
#(
  parameter int unsigned POOL_COUNT = 3,
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_buf_index,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                out_ready,
  output logic                out_valid,
  output result_t             res
);

  localparam int unsigned IDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int unsigned REM_W = $clog2(LINE_BYTES);
  localparam int unsigned PROD_W = IDX_W + FBYTES_W;
  // Remainder folding: low half width, folded operand width, reciprocal
  localparam int unsigned LO_W     = 16;
  localparam int unsigned Y_W      = REM_W + LO_W;
  localparam int unsigned RECIP_SH = Y_W + REM_W;
  localparam logic [Y_W:0] RECIP =
    (Y_W+1)'(((64'd1 << RECIP_SH) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES));

  // Remainder by the line size through a reciprocal multiply
  function automatic logic [REM_W-1:0] line_rem(input logic [Y_W-1:0] y);
    logic [2*Y_W:0] prod_q;
    logic [Y_W-1:0] quo;
    logic [Y_W-1:0] back;
    prod_q = (2*Y_W+1)'(y) * (2*Y_W+1)'(RECIP);
    quo    = Y_W'(prod_q >> RECIP_SH);
    back   = y - quo * Y_W'(LINE_BYTES);
    return REM_W'(back);
  endfunction

  // Configuration registers
  logic [ADDR_W-1:0]   base_r;
  logic [FBYTES_W-1:0] fbytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      fbytes_r <= FRAME_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE_ADDR: base_r   <= cfg_data;
        REG_FRAME_BYTES:    fbytes_r <= cfg_data[FBYTES_W-1:0];
        default:            base_r   <= base_r;
      endcase
    end
  end

  // Capture the event word
  logic [2:0] op_r;
  logic [7:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      idx_r <= in_buf_index;
    end
  end

  logic             idx_ok;
  logic [IDX_W-1:0] ti;
  assign idx_ok = (idx_r < 8'(POOL_COUNT));
  assign ti     = idx_r[IDX_W-1:0];

  // Buffer start: base plus index times frame size
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr_c;
  logic [END_W-1:0]  end_c;
  assign prod   = PROD_W'(ti) * PROD_W'(fbytes_r);
  assign addr_c = base_r + ADDR_W'(prod);
  assign end_c  = {1'b0, addr_c} + END_W'(fbytes_r);

  // Remainder pass: upper half of start and end first, then the lower half
  logic [ADDR_W-1:0] addr_r;
  logic [END_W-1:0]  end_r;
  logic [REM_W-1:0]  rs_r;
  logic [REM_W-1:0]  re_r;
  logic [STEP_W-1:0] step_r;
  logic [END_W-1:0]  start_ext;
  logic [Y_W-1:0]    ys;
  logic [Y_W-1:0]    ye;
  logic [REM_W-1:0]  rs_nxt;
  logic [REM_W-1:0]  re_nxt;

  assign start_ext = {1'b0, addr_r};

  always_comb begin
    if (step_r == '0) begin
      ys = Y_W'(start_ext[END_W-1:LO_W]);
      ye = Y_W'(end_r[END_W-1:LO_W]);
    end else begin
      ys = {rs_r, start_ext[LO_W-1:0]};
      ye = {re_r, end_r[LO_W-1:0]};
    end
  end

  assign rs_nxt = line_rem(ys);
  assign re_nxt = line_rem(ye);

  always_ff @(posedge clk) begin
    if (cmd.addr_load) begin
      addr_r <= addr_c;
      end_r  <= end_c;
      rs_r   <= '0;
      re_r   <= '0;
      step_r <= '0;
    end else if (cmd.mod_step) begin
      rs_r   <= rs_nxt;
      re_r   <= re_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign stat.mod_last = (step_r == STEP_W'(MOD_STEPS - 1));

  // Line-aligned range
  logic [ADDR_W-1:0] down;
  logic [ADDR_W-1:0] pad;
  logic [ADDR_W-1:0] len;
  assign down = addr_r - ADDR_W'(rs_r);
  assign pad  = (re_r == '0) ? '0 : ADDR_W'(LINE_BYTES) - ADDR_W'(re_r);
  assign len  = end_r[ADDR_W-1:0] + pad - down;

  // Owner, sequence and generation tables
  owner_t             own_tbl_r [POOL_COUNT];
  logic [CNT32_W-1:0] seq_tbl_r [POOL_COUNT];
  logic [CNT32_W-1:0] gen_tbl_r [POOL_COUNT];
  logic [CNT32_W-1:0] stale_r;
  logic [CNT32_W-1:0] reuse_r;

  owner_t             own;
  owner_t             own_nxt;
  logic [CNT32_W-1:0] seq_nxt;
  logic [CNT32_W-1:0] gen_nxt;
  logic [CNT32_W-1:0] stale_nxt;
  logic [CNT32_W-1:0] reuse_nxt;
  result_t            res_nxt;

  assign own = idx_ok ? own_tbl_r[ti] : OWN_FREE;

  // Check owner and build the result
  always_comb begin
    own_nxt   = own;
    seq_nxt   = idx_ok ? seq_tbl_r[ti] : '0;
    gen_nxt   = idx_ok ? gen_tbl_r[ti] : '0;
    stale_nxt = stale_r;
    reuse_nxt = reuse_r;
    res_nxt   = '0;
    if (idx_ok) begin
      case (op_r)
        OP_PREP_RX: begin
          if (own != OWN_FREE) begin
            reuse_nxt = reuse_r + 1'b1;
          end else begin
            own_nxt            = OWN_DMA_RX;
            res_nxt.ok         = 1'b1;
            res_nxt.dma_action = DMA_CAM_RX;
            res_nxt.dma_addr   = addr_r;
          end
        end
        OP_RX_DONE: begin
          seq_nxt              = seq_nxt + 1'b1;
          own_nxt              = OWN_CPU;
          res_nxt.ok           = 1'b1;
          res_nxt.cache_action = CACHE_INVALIDATE;
          res_nxt.cache_addr   = down;
          res_nxt.cache_len    = len;
        end
        OP_QUEUE: begin
          if (own != OWN_CPU) begin
            stale_nxt = stale_r + 1'b1;
          end else begin
            own_nxt            = OWN_QUEUED;
            res_nxt.ok         = 1'b1;
            res_nxt.queue_push = 1'b1;
          end
        end
        OP_LCD_SUBMIT: begin
          if (own != OWN_QUEUED) begin
            stale_nxt = stale_r + 1'b1;
          end else begin
            own_nxt              = OWN_DISPLAY;
            res_nxt.ok           = 1'b1;
            res_nxt.cache_action = CACHE_CLEAN;
            res_nxt.cache_addr   = down;
            res_nxt.cache_len    = len;
            res_nxt.dma_action   = DMA_LCD_TX;
            res_nxt.dma_addr     = addr_r;
          end
        end
        OP_FLUSH_DONE: begin
          gen_nxt    = gen_nxt + 1'b1;
          own_nxt    = OWN_FREE;
          res_nxt.ok = 1'b1;
        end
        default: begin
          own_nxt = own;
        end
      endcase
    end
    res_nxt.owner_after      = own_nxt;
    res_nxt.frame_seq        = seq_nxt;
    res_nxt.frame_generation = gen_nxt;
    res_nxt.stale_total      = stale_nxt;
    res_nxt.reuse_total      = reuse_nxt;
  end

  // Write back state on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        own_tbl_r[i] <= OWN_FREE;
        seq_tbl_r[i] <= '0;
        gen_tbl_r[i] <= CNT32_W'(1);
      end
      stale_r <= '0;
      reuse_r <= '0;
    end else if (cmd.commit) begin
      if (idx_ok) begin
        own_tbl_r[ti] <= own_nxt;
        seq_tbl_r[ti] <= seq_nxt;
        gen_tbl_r[ti] <= gen_nxt;
      end
      stale_r <= stale_nxt;
      reuse_r <= reuse_nxt;
    end
  end

  // Output register: load on commit, drop when taken
  logic    out_valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign res           = res_r;

endmodule

// ===== sv/dma_frame_buffer_owner_tracker.sv =====
// Top level of the DMA frame buffer owner tracker.
//
// Tracks which party owns each buffer of a pool of POOL_COUNT frame buffers
// (free, camera receive, CPU, queued, display). An event word on the in_
// channel names an operation and a buffer index; each event yields exactly
// one result word on the out_ channel with the owner check outcome, the new
// owner, sequence and generation counts, the line-aligned cache range to
// invalidate or clean, any DMA start and any queue push request.
// Buffer i sits at pool_base_addr + i * frame_bytes; cache ranges are
// aligned to LINE_BYTES.
// Sequence: the event word is captured, the buffer address is computed and
// registered, then the line alignment folds the upper and then the lower
// half of each address through a reciprocal-multiply remainder unit, and
// finally the tables commit and the result word is registered.
// A new word is taken only once the last one has committed; in_ready is
// high only while no word is in flight. A result waiting in the output
// register does not block the next event; only its commit waits until
// out_ready frees the register.
// Reset (rst_n low, synchronous) frees all buffers, clears sequence counts
// and refusal counters, sets generations to one and restores the
// configuration registers. Write cfg_ only while no word is in flight.
module dma_frame_buffer_owner_tracker
  import dfbot_pkg::*;
#(
  parameter int unsigned POOL_COUNT = 3,
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_buf_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [2:0]  out_owner_after,
  output logic [31:0] out_frame_seq,
  output logic [31:0] out_frame_generation,
  output logic [1:0]  out_cache_action,
  output logic [31:0] out_cache_addr,
  output logic [31:0] out_cache_len,
  output logic [1:0]  out_dma_action,
  output logic [31:0] out_dma_addr,
  output logic        out_queue_push,
  output logic [31:0] out_stale_total,
  output logic [31:0] out_reuse_total
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;

  // Sequencer
  dfbot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, address math and result register
  dfbot_dp #(
    .POOL_COUNT (POOL_COUNT),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_op        (in_op),
    .in_buf_index (in_buf_index),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .res          (res)
  );

  // Unpack the result word
  assign out_ok               = res.ok;
  assign out_owner_after      = res.owner_after;
  assign out_frame_seq        = res.frame_seq;
  assign out_frame_generation = res.frame_generation;
  assign out_cache_action     = res.cache_action;
  assign out_cache_addr       = res.cache_addr;
  assign out_cache_len        = res.cache_len;
  assign out_dma_action       = res.dma_action;
  assign out_dma_addr         = res.dma_addr;
  assign out_queue_push       = res.queue_push;
  assign out_stale_total      = res.stale_total;
  assign out_reuse_total      = res.reuse_total;

endmodule
